FILE: sv/http_chunked_body_framer_defines.svh
// ----------------------------------------------------------------------------
// http_chunked_body_framer_defines
// assertion macros used by the framer checker
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_FRAMER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_FRAMER_DEFINES_SVH

// checked only out of reset
`define HCBF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HCBF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/hcbf_pkg.sv
// ----------------------------------------------------------------------------
// hcbf_pkg
// item types, job descriptor and character constants of the chunked framer
// ----------------------------------------------------------------------------
package hcbf_pkg;

  typedef enum logic [1:0] {
    CMD_ENTER   = 2'd0,
    CMD_OPEN    = 2'd1,
    CMD_PAYLOAD = 2'd2,
    CMD_FINISH  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,
    JOB_ERROR  = 2'd1,
    JOB_HEADER = 2'd2,
    JOB_TERM   = 2'd3
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] chunk_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    job_kind_e   kind;
    logic        crlf;
    logic [7:0]  data_byte;
    logic [3:0]  num_digits;
    logic [31:0] length;
  } job_t;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ALPHA  = 8'h37;
  localparam logic [3:0] TERM_LEN    = 4'd5;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'hA) begin
      ch = CHAR_ZERO + {4'd0, nib};
    end else begin
      ch = CHAR_ALPHA + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

FILE: sv/http_chunked_body_framer.sv
// ----------------------------------------------------------------------------
// http_chunked_body_framer
// an item's first result passes the job queue, then the output register
// throughput: one item per cycle if each gives at most one byte and no stall
// emitter: one byte a cycle unless stalled; open gives digits+2, finish 5
// reset: async active low, raw pass-through mode, no chunk open, queue empty
// ----------------------------------------------------------------------------
module http_chunked_body_framer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hcbf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbf_pkg::out_item_t out_item_o
);
  import hcbf_pkg::*;

  logic q_full, q_empty, push, pop;
  job_t push_job, head_job;

  hcbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  hcbf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  hcbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: sv/hcbf_fifo.sv
// ----------------------------------------------------------------------------
// hcbf_fifo
// short job queue between the classifier and the byte emitter
// ----------------------------------------------------------------------------
module hcbf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcbf_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output hcbf_pkg::job_t  head_o
);
  import hcbf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/hcbf_front.sv
// ----------------------------------------------------------------------------
// hcbf_front
// accepts command items, tracks chunk state and queues emit jobs
// ----------------------------------------------------------------------------
module hcbf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hcbf_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output hcbf_pkg::job_t     job_o
);
  import hcbf_pkg::*;

  logic        chunked_q, chunked_d;
  logic [31:0] left_q, left_d;
  logic        accept;
  logic        has_job;
  logic [3:0]  ndig;
  logic [7:0][3:0] nibs;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_job;
  assign nibs       = in_item_i.chunk_length;

  // hex digit count without leading zeros
  always_comb begin
    ndig = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (nibs[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  always_comb begin
    chunked_d        = chunked_q;
    left_d           = left_q;
    has_job          = 1'b0;
    job_o.kind       = JOB_ERROR;
    job_o.crlf       = 1'b0;
    job_o.data_byte  = in_item_i.data_byte;
    job_o.num_digits = ndig;
    job_o.length     = in_item_i.chunk_length;
    case (cmd_e'(in_item_i.command))
      CMD_ENTER: begin
        chunked_d = 1'b1;
      end
      CMD_OPEN: begin
        if (!chunked_q || left_q != '0) begin
          has_job = 1'b1;
        end else if (in_item_i.chunk_length != '0) begin
          has_job    = 1'b1;
          job_o.kind = JOB_HEADER;
          left_d     = in_item_i.chunk_length;
        end
      end
      CMD_PAYLOAD: begin
        has_job = 1'b1;
        if (!chunked_q) begin
          job_o.kind = JOB_BYTE;
        end else if (left_q != '0) begin
          job_o.kind = JOB_BYTE;
          job_o.crlf = (left_q == 32'd1);
          left_d     = left_q - 32'd1;
        end
      end
      CMD_FINISH: begin
        if (chunked_q) begin
          has_job = 1'b1;
          if (left_q == '0) begin
            job_o.kind = JOB_TERM;
          end
        end
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_q <= 1'b0;
      left_q    <= '0;
    end else if (accept) begin
      chunked_q <= chunked_d;
      left_q    <= left_d;
    end
  end

endmodule

FILE: sv/hcbf_back.sv
// ----------------------------------------------------------------------------
// hcbf_back
// walks the queued job one byte a cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module hcbf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  hcbf_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbf_pkg::out_item_t out_item_o
);
  import hcbf_pkg::*;

  logic [3:0]      step_q, step_d;
  logic [3:0]      count;
  logic [3:0]      digit_off;
  logic [2:0]      nib_idx;
  logic [7:0][3:0] nibs;
  logic            load;
  logic            is_last;
  out_item_t       cur;
  logic            out_valid_q;
  out_item_t       out_q;

  assign nibs      = head_i.length;
  assign digit_off = head_i.num_digits - 4'd1 - step_q;
  assign nib_idx   = digit_off[2:0];

  always_comb begin
    count     = 4'd1;
    cur.error = 1'b0;
    cur.out_byte = head_i.data_byte;
    case (head_i.kind)
      JOB_BYTE: begin
        count = head_i.crlf ? 4'd3 : 4'd1;
        if (step_q == 4'd1) begin
          cur.out_byte = CHAR_CR;
        end else if (step_q == 4'd2) begin
          cur.out_byte = CHAR_LF;
        end
      end
      JOB_ERROR: begin
        cur.error    = 1'b1;
        cur.out_byte = '0;
      end
      JOB_HEADER: begin
        count = head_i.num_digits + 4'd2;
        if (step_q < head_i.num_digits) begin
          cur.out_byte = hex_char(nibs[nib_idx]);
        end else if (step_q == head_i.num_digits) begin
          cur.out_byte = CHAR_CR;
        end else begin
          cur.out_byte = CHAR_LF;
        end
      end
      JOB_TERM: begin
        count = TERM_LEN;
        if (step_q == 4'd0) begin
          cur.out_byte = CHAR_ZERO;
        end else if (step_q[0]) begin
          cur.out_byte = CHAR_CR;
        end else begin
          cur.out_byte = CHAR_LF;
        end
      end
      default: begin
        count = 4'd1;
      end
    endcase
    is_last  = (step_q == count - 4'd1);
    cur.last = is_last;
  end

  assign load   = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o  = load && is_last;
  assign step_d = load ? (is_last ? 4'd0 : step_q + 4'd1) : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sv/hcbf_checker.sv
// ----------------------------------------------------------------------------
// hcbf_checker
// port level checks of the chunked framer, bound to the top level
// ----------------------------------------------------------------------------
`include "http_chunked_body_framer_defines.svh"

module hcbf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input hcbf_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hcbf_pkg::out_item_t out_item_o
);
  import hcbf_pkg::*;

  `HCBF_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i), "in item changed")
  `HCBF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out item dropped")
  `HCBF_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_item_o), "out item changed")
  `HCBF_ASSERT(a_err_form, clk_i, rst_ni, out_valid_o && out_item_o.error |-> out_item_o.last && out_item_o.out_byte == 8'd0, "bad error item")
  `HCBF_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> !out_valid_o, "output after reset")

endmodule

bind http_chunked_body_framer hcbf_checker u_hcbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chunked body framer: directed raw and chunked
// sequences, then random well-formed chunks mixed with out-of-order commands,
// under random idling on both handshakes; every output item is checked
// against a behavioral copy of the framer
// ----------------------------------------------------------------------------
module tb_top;
  import hcbf_pkg::*;

  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam int unsigned RANDOM_ITEMS = 500;

  class body_framer_sb;
    bit          chunked;
    logic [31:0] remaining;
    out_item_t   framed_bytes[$];
    int unsigned fail_count;

    function new();
      chunked    = 1'b0;
      remaining  = '0;
      fail_count = 0;
    endfunction

    function out_item_t data_result(logic [7:0] b);
      out_item_t o;
      o.out_byte = b;
      o.last     = 1'b0;
      o.error    = 1'b0;
      return o;
    endfunction

    function out_item_t error_result();
      out_item_t o;
      o.out_byte = 8'h00;
      o.last     = 1'b0;
      o.error    = 1'b1;
      return o;
    endfunction

    function void accept_command(in_item_t it);
      out_item_t  burst[$];
      out_item_t  o;
      logic [3:0] nib;
      bit         started;
      started = 1'b0;
      case (cmd_e'(it.command))
        CMD_ENTER: begin
          chunked = 1'b1;
        end
        CMD_OPEN: begin
          if (!chunked || remaining != 0) begin
            burst.push_back(error_result());
          end else if (it.chunk_length != 0) begin
            for (int i = 7; i >= 0; i--) begin
              nib = it.chunk_length[i*4 +: 4];
              if (nib != 4'h0) started = 1'b1;
              if (started) begin
                if (nib < 4'hA) burst.push_back(data_result(ASCII_ZERO + {4'h0, nib}));
                else burst.push_back(data_result(ASCII_A - 8'd10 + {4'h0, nib}));
              end
            end
            burst.push_back(data_result(ASCII_CR));
            burst.push_back(data_result(ASCII_LF));
            remaining = it.chunk_length;
          end
        end
        CMD_PAYLOAD: begin
          if (!chunked) begin
            burst.push_back(data_result(it.data_byte));
          end else if (remaining == 0) begin
            burst.push_back(error_result());
          end else begin
            burst.push_back(data_result(it.data_byte));
            remaining = remaining - 1;
            if (remaining == 0) begin
              burst.push_back(data_result(ASCII_CR));
              burst.push_back(data_result(ASCII_LF));
            end
          end
        end
        default: begin
          if (chunked) begin
            if (remaining != 0) begin
              burst.push_back(error_result());
            end else begin
              burst.push_back(data_result(ASCII_ZERO));
              burst.push_back(data_result(ASCII_CR));
              burst.push_back(data_result(ASCII_LF));
              burst.push_back(data_result(ASCII_CR));
              burst.push_back(data_result(ASCII_LF));
            end
          end
        end
      endcase
      foreach (burst[k]) begin
        o = burst[k];
        o.last = (k == burst.size() - 1);
        framed_bytes.push_back(o);
      end
    endfunction

    function void check_output_byte(out_item_t got);
      out_item_t want;
      if (framed_bytes.size() == 0) begin
        $error("output item with none expected: out_byte %0h last %0b error %0b",
               got.out_byte, got.last, got.error);
        fail_count++;
        return;
      end
      want = framed_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        fail_count++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0b, got %0b", want.error, got.error);
        fail_count++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  body_framer_sb sb = new();
  int unsigned   items_sent;
  bit            calm;

  http_chunked_body_framer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.accept_command(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_output_byte(out_item_o);
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // caller sits at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(cmd_e cmd, logic [31:0] len, logic [7:0] data);
    in_item_t it;
    it.command      = cmd;
    it.chunk_length = len;
    it.data_byte    = data;
    calm = (items_sent >= 200 && items_sent < 320);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // open plus its payload, with optional out-of-order commands inside the chunk
  task automatic send_chunk(int unsigned n, bit noisy);
    send_item(CMD_OPEN, n, 8'($urandom_range(0, 255)));
    for (int unsigned k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 99) < 4) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_OPEN, $urandom, 8'($urandom_range(0, 255)));
        end else begin
          send_item(CMD_FINISH, $urandom, 8'($urandom_range(0, 255)));
        end
      end
      send_item(CMD_PAYLOAD, $urandom, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned waited;
    int unsigned len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    items_sent  = 0;
    calm        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // raw pass-through
    send_item(CMD_PAYLOAD, 32'h0, 8'h00);
    send_item(CMD_PAYLOAD, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_OPEN, 32'd5, 8'h00);
    send_item(CMD_FINISH, 32'h0, 8'h00);
    // chunked mode corner cases
    send_item(CMD_ENTER, 32'h0, 8'h00);
    send_item(CMD_PAYLOAD, 32'h0, 8'h5A);
    send_item(CMD_OPEN, 32'h0, 8'h00);
    send_item(CMD_FINISH, 32'h0, 8'h00);
    send_item(CMD_OPEN, 32'd1, 8'h00);
    send_item(CMD_FINISH, 32'h0, 8'h00);
    send_item(CMD_OPEN, 32'd3, 8'h00);
    send_item(CMD_PAYLOAD, 32'h0, 8'hA5);
    send_item(CMD_ENTER, 32'h0, 8'h00);
    send_item(CMD_OPEN, 32'h0, 8'h00);
    send_chunk(2, 1'b0);
    send_item(CMD_FINISH, 32'h0, 8'h00);
    send_item(CMD_OPEN, 32'd1, 8'hFF);
    send_item(CMD_PAYLOAD, 32'hFFFF_FFFF, 8'h00);

    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 11) == 0) len = $urandom_range(21, 300);
        else len = $urandom_range(1, 20);
        send_chunk(len, 1'b1);
        if ($urandom_range(0, 3) == 0) begin
          send_item(CMD_FINISH, $urandom, 8'($urandom_range(0, 255)));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(CMD_PAYLOAD, $urandom, 8'($urandom_range(0, 255)));
          1: send_item(CMD_OPEN, 32'h0, 8'($urandom_range(0, 255)));
          2: send_item(CMD_ENTER, $urandom, 8'($urandom_range(0, 255)));
          default: send_item(CMD_FINISH, $urandom, 8'($urandom_range(0, 255)));
        endcase
      end
    end

    // widest header; the chunk stays open for the rest of the run
    send_item(CMD_OPEN, 32'hFEDC_BA98, 8'h00);
    send_item(CMD_PAYLOAD, 32'h0, 8'h3C);
    send_item(CMD_OPEN, 32'hFFFF_FFFF, 8'h00);
    send_item(CMD_FINISH, 32'h0, 8'h00);
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.framed_bytes.size() != 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.framed_bytes.size() != 0) begin
      $error("%0d expected output items never arrived", sb.framed_bytes.size());
    end
    if (sb.fail_count == 0 && sb.framed_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
